// ===== rtl/tufg_pkg.sv =====
// Package for the texture upload footprint generator.
// Holds the field widths, the register map, and the command and status types.
// It depends on nothing else.
package tufg_pkg;

	localparam int MAX_MIPS_DEF = 15;
	localparam int DIV_W        = 48;
	localparam int DVS_W        = 18;
	localparam int OFS_W        = 48;

	localparam logic [4:0]  BB_RST = 5'd4;
	localparam logic [3:0]  BW_RST = 4'd1;
	localparam logic [3:0]  BH_RST = 4'd1;
	localparam logic [16:0] OA_RST = 17'd512;
	localparam logic [16:0] PA_RST = 17'd256;

	// Register indexes (byte address / 4)
	typedef enum logic [2:0] {
		REG_BB = 3'd0,
		REG_BW = 3'd1,
		REG_BH = 3'd2,
		REG_OA = 3'd3,
		REG_PA = 3'd4
	} reg_idx_t;

	// Which operand pair the shared divider is working on
	typedef enum logic [2:0] {
		DS_EFF = 3'd0,
		DS_W   = 3'd1,
		DS_H   = 3'd2,
		DS_P   = 3'd3,
		DS_O   = 3'd4
	} div_sel_t;

	typedef struct packed {
		logic [4:0]  block_bytes;
		logic [3:0]  block_texel_width;
		logic [3:0]  block_texel_height;
		logic [16:0] offset_alignment;
		logic [16:0] pitch_alignment;
	} cfg_t;

	typedef struct packed {
		logic     load;
		logic     div_start;
		div_sel_t div_sel;
		logic     mul;
		logic     surf;
		logic     add;
		logic     advance;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic cnt_zero;
		logic last;
	} status_t;

endpackage

// ===== rtl/tufg_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Uses tufg_pkg for the operand widths.
module tufg_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [tufg_pkg::DIV_W-1:0] dividend,
	input  logic [tufg_pkg::DVS_W-1:0] divisor,
	output logic                       done,
	output logic [tufg_pkg::DIV_W-1:0] quo,
	output logic [tufg_pkg::DVS_W-1:0] rem
);
	import tufg_pkg::*;

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [DIV_W-1:0] q_q;
	logic [DVS_W-1:0] r_q;
	logic [DVS_W-1:0] d_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DVS_W:0]   trial;
	logic             take;

	// shift in the next dividend bit and try a subtract
	assign trial = {r_q, q_q[DIV_W-1]};
	assign take  = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(DIV_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (cnt_q != '0) begin
			q_q <= {q_q[DIV_W-2:0], take};
			r_q <= take ? DVS_W'(trial - {1'b0, d_q}) : trial[DVS_W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = q_q;
	assign rem  = r_q;

endmodule

// ===== rtl/tufg_ctrl.sv =====
// Controller: sequences the divisions, multiplies and record hand-off per mip.
// Uses tufg_pkg for the command and status types.
module tufg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  tufg_pkg::status_t st,
	output tufg_pkg::cmd_t    cmd
);
	import tufg_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_DSTART = 7'b0000010,
		S_DWAIT  = 7'b0000100,
		S_MUL    = 7'b0001000,
		S_SURF   = 7'b0010000,
		S_ADD    = 7'b0100000,
		S_EMIT   = 7'b1000000
	} state_t;

	state_t   state_q, state_d;
	div_sel_t phase_q, phase_d;

	// next state
	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = S_DSTART;
					phase_d = DS_EFF;
				end
			end
			S_DSTART: state_d = S_DWAIT;
			S_DWAIT: begin
				if (st.div_done) begin
					state_d = S_DSTART;
					case (phase_q)
						DS_EFF: begin
							phase_d = DS_W;
							if (st.cnt_zero) state_d = S_IDLE;
						end
						DS_W:    phase_d = DS_H;
						DS_H:    phase_d = DS_P;
						DS_P:    phase_d = DS_O;
						DS_O:    state_d = S_MUL;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_MUL:  state_d = S_SURF;
			S_SURF: state_d = S_ADD;
			S_ADD:  state_d = S_EMIT;
			S_EMIT: begin
				if (m_tready) begin
					state_d = st.last ? S_IDLE : S_DSTART;
					phase_d = DS_W;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= DS_EFF;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

	// commands
	always_comb begin
		cmd           = '0;
		cmd.div_sel   = phase_q;
		cmd.load      = (state_q == S_IDLE) && s_tvalid;
		cmd.div_start = state_q == S_DSTART;
		cmd.mul       = state_q == S_MUL;
		cmd.surf      = state_q == S_SURF;
		cmd.add       = state_q == S_ADD;
		cmd.advance   = (state_q == S_EMIT) && m_tready;
	end

	assign s_tready = state_q == S_IDLE;
	assign m_tvalid = state_q == S_EMIT;

endmodule

// ===== rtl/tufg_dp.sv =====
// Datapath: mip extents, running offset and total, and per-mip record fields.
// Uses tufg_pkg and instantiates the shared divider tufg_div.
module tufg_dp #(
	parameter int MAX_MIPS = tufg_pkg::MAX_MIPS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tufg_pkg::cfg_t    cfg,
	input  tufg_pkg::cmd_t    cmd,
	input  logic [14:0]       in_width,
	input  logic [14:0]       in_height,
	input  logic [11:0]       in_depth,
	input  logic [3:0]        in_mips,
	input  logic [10:0]       in_layer,
	input  logic [47:0]       in_base,
	input  logic              in_start,
	output tufg_pkg::status_t st,
	output logic [14:0]       sub_index,
	output logic [47:0]       buffer_offset,
	output logic [31:0]       row_pitch,
	output logic [31:0]       row_bytes,
	output logic [31:0]       slice_pitch,
	output logic [14:0]       row_total,
	output logic [11:0]       slice_total,
	output logic [47:0]       running_total
);
	import tufg_pkg::*;

	localparam int CW = $clog2(MAX_MIPS + 1);

	logic [14:0]      w_q, h_q;
	logic [11:0]      d_q;
	logic [CW-1:0]    cnt_q, m_q;
	logic [14:0]      idx_base_q;
	logic [OFS_W-1:0] ro_q, tot_q;
	logic [DVS_W-1:0] eff_q;
	logic [31:0]      rb_q, pitch_q, slice_q;
	logic [14:0]      rows_q;
	logic [43:0]      surf_q;

	logic [DIV_W-1:0] dvd, quo;
	logic [DVS_W-1:0] dvs, rem;
	logic             done;
	logic             rem_nz;
	logic [DVS_W-1:0] bb_nz, bw_nz, bh_nz, pa_nz, oa_up;
	logic [16:0]      oa_nz;
	logic [4:0]       mips5, cnt5;
	logic [14:0]      ceil15;
	logic [DVS_W-1:0] fix;

	// effective register values, zero acting as one
	assign bb_nz = (cfg.block_bytes == '0) ? DVS_W'(1) : DVS_W'(cfg.block_bytes);
	assign bw_nz = (cfg.block_texel_width == '0) ? DVS_W'(1) : DVS_W'(cfg.block_texel_width);
	assign bh_nz = (cfg.block_texel_height == '0) ? DVS_W'(1) : DVS_W'(cfg.block_texel_height);
	assign pa_nz = (cfg.pitch_alignment == '0) ? DVS_W'(1) : DVS_W'(cfg.pitch_alignment);
	assign oa_nz = (cfg.offset_alignment == '0) ? 17'd1 : cfg.offset_alignment;
	assign oa_up = (DVS_W'(oa_nz) + DVS_W'(3)) & ~DVS_W'(3);

	// divider operand select
	always_comb begin
		case (cmd.div_sel)
			DS_EFF:  begin dvd = DIV_W'(oa_up);   dvs = bb_nz; end
			DS_W:    begin dvd = DIV_W'(w_q);     dvs = bw_nz; end
			DS_H:    begin dvd = DIV_W'(h_q);     dvs = bh_nz; end
			DS_P:    begin dvd = DIV_W'(rb_q);    dvs = pa_nz; end
			DS_O:    begin dvd = ro_q;            dvs = eff_q; end
			default: begin dvd = '0;              dvs = DVS_W'(1); end
		endcase
	end

	tufg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dvd),
		.divisor  (dvs),
		.done     (done),
		.quo      (quo),
		.rem      (rem)
	);

	// round-up helpers: ceil quotient and pad to the next multiple
	assign rem_nz = rem != '0;
	assign ceil15 = quo[14:0] + 15'(rem_nz);
	assign fix    = rem_nz ? DVS_W'(dvs - rem) : '0;

	assign mips5 = {1'b0, in_mips};
	assign cnt5  = (mips5 > 5'(MAX_MIPS)) ? 5'(MAX_MIPS) : mips5;

	// item-level control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ro_q  <= '0;
			tot_q <= '0;
			cnt_q <= '0;
			m_q   <= '0;
		end else begin
			if (cmd.load) begin
				cnt_q <= CW'(cnt5);
				m_q   <= '0;
				if (in_start) begin
					ro_q  <= in_base;
					tot_q <= '0;
				end
			end else if (done && cmd.div_sel == DS_O) begin
				ro_q  <= ro_q + OFS_W'(fix);
				tot_q <= tot_q + OFS_W'(fix);
			end else if (cmd.add) begin
				tot_q <= tot_q + OFS_W'(surf_q);
			end else if (cmd.advance) begin
				ro_q <= ro_q + OFS_W'(surf_q);
				m_q  <= m_q + 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			w_q        <= in_width;
			h_q        <= in_height;
			d_q        <= in_depth;
			idx_base_q <= 15'(in_layer) * 15'(in_mips);
		end else if (cmd.advance) begin
			w_q <= (w_q[14:1] == '0) ? 15'd1 : {1'b0, w_q[14:1]};
			h_q <= (h_q[14:1] == '0) ? 15'd1 : {1'b0, h_q[14:1]};
			d_q <= (d_q[11:1] == '0) ? 12'd1 : {1'b0, d_q[11:1]};
		end
		if (done) begin
			case (cmd.div_sel)
				DS_EFF:  eff_q   <= oa_up + fix;
				DS_W:    rb_q    <= 32'(ceil15) * 32'(cfg.block_bytes);
				DS_H:    rows_q  <= ceil15;
				DS_P:    pitch_q <= rb_q + 32'(fix);
				default: ;
			endcase
		end
		if (cmd.mul) slice_q <= 32'(pitch_q * rows_q);
		if (cmd.surf) surf_q <= slice_q * d_q;
	end

	assign st.div_done = done;
	assign st.cnt_zero = cnt_q == '0;
	assign st.last     = (m_q + 1'b1) == cnt_q;

	assign sub_index     = idx_base_q + 15'(m_q);
	assign buffer_offset = ro_q;
	assign row_pitch     = pitch_q;
	assign row_bytes     = rb_q;
	assign slice_pitch   = slice_q;
	assign row_total     = rows_q;
	assign slice_total   = d_q;
	assign running_total = tot_q;

endmodule

// ===== rtl/texture_upload_footprint_gen_core.sv =====
// Top level of the texture upload footprint generator: APB registers,
// stream ports, controller and datapath. Depends on tufg_pkg, tufg_ctrl, tufg_dp.
//
// Each input item describes one array layer of an image and produces one
// record per mip level (up to MAX_MIPS), the last flagged with m_tlast.
// The start flag in s_tuser reloads the running offset from base_offset and
// clears the running total before the layer is laid out. One item is worked
// on at a time; s_tready is high only when the block is idle. All rounding
// goes through one shared 48-step divider: an item takes one division for the
// offset alignment after the accept, then per mip four divisions, the slice
// multiply, surface multiply and total add steps, and the record hand-off.
// A record waits while m_tready is low; the next mip starts once it is taken.
// The user must write configuration over APB only while no item is in flight;
// the block itself does not enforce this.
module texture_upload_footprint_gen_core #(
	parameter int MAX_MIPS = tufg_pkg::MAX_MIPS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	// APB configuration
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	// input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	// image_width[14:0] image_height[29:15] image_depth[41:30] mip_count[45:42]
	// layer_count[57:46] layer_index[68:58] base_offset[116:69], zero pad
	input  logic [119:0] s_tdata,
	input  logic         s_tuser, // start_image
	// output stream
	output logic         m_tvalid,
	input  logic         m_tready,
	// subresource_index[14:0] buffer_offset[62:15] row_pitch[94:63]
	// row_bytes[126:95] slice_pitch[158:127] row_total[173:159]
	// slice_total[185:174] running_total[233:186], zero pad
	output logic [239:0] m_tdata,
	output logic         m_tlast  // last_mip
);
	import tufg_pkg::*;

	cfg_t    cfg_q;
	cmd_t    cmd;
	status_t st;
	logic [14:0] sub_idx, rows;
	logic [47:0] boff, rtot;
	logic [31:0] pitch, rbytes, spitch;
	logic [11:0] slices;
	reg_idx_t    ridx;

	assign ridx   = reg_idx_t'(paddr[4:2]);
	assign pready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.block_bytes        <= BB_RST;
			cfg_q.block_texel_width  <= BW_RST;
			cfg_q.block_texel_height <= BH_RST;
			cfg_q.offset_alignment   <= OA_RST;
			cfg_q.pitch_alignment    <= PA_RST;
		end else if (psel && penable && pwrite) begin
			case (ridx)
				REG_BB:  cfg_q.block_bytes        <= pwdata[4:0];
				REG_BW:  cfg_q.block_texel_width  <= pwdata[3:0];
				REG_BH:  cfg_q.block_texel_height <= pwdata[3:0];
				REG_OA:  cfg_q.offset_alignment   <= pwdata[16:0];
				REG_PA:  cfg_q.pitch_alignment    <= pwdata[16:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		case (ridx)
			REG_BB:  prdata = 32'(cfg_q.block_bytes);
			REG_BW:  prdata = 32'(cfg_q.block_texel_width);
			REG_BH:  prdata = 32'(cfg_q.block_texel_height);
			REG_OA:  prdata = 32'(cfg_q.offset_alignment);
			REG_PA:  prdata = 32'(cfg_q.pitch_alignment);
			default: prdata = '0;
		endcase
	end

	tufg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.st       (st),
		.cmd      (cmd)
	);

	tufg_dp #(.MAX_MIPS(MAX_MIPS)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.cmd           (cmd),
		.in_width      (s_tdata[14:0]),
		.in_height     (s_tdata[29:15]),
		.in_depth      (s_tdata[41:30]),
		.in_mips       (s_tdata[45:42]),
		.in_layer      (s_tdata[68:58]),
		.in_base       (s_tdata[116:69]),
		.in_start      (s_tuser),
		.st            (st),
		.sub_index     (sub_idx),
		.buffer_offset (boff),
		.row_pitch     (pitch),
		.row_bytes     (rbytes),
		.slice_pitch   (spitch),
		.row_total     (rows),
		.slice_total   (slices),
		.running_total (rtot)
	);

	assign m_tdata = {6'd0, rtot, slices, rows, spitch, rbytes, pitch, boff, sub_idx};
	assign m_tlast = st.last;

endmodule
